### rtl/bvh_nearest_cache_entry_search_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the BVH cache entry search
// Shared property forms; clk and rst_n are taken from the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef BVH_NEAREST_CACHE_ENTRY_SEARCH_DEFINES_SVH
`define BVH_NEAREST_CACHE_ENTRY_SEARCH_DEFINES_SVH

// condition implies consequence in the same cycle
`define BNCES_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bnces assertion failed");

// condition implies consequence in the next cycle
`define BNCES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bnces assertion failed");

`endif

### rtl/bnces_pkg.sv
// ---------------------------------------------------------------------------
// bnces_pkg
// Types, sizes and codes shared by the BVH cache entry search modules.
// ---------------------------------------------------------------------------
package bnces_pkg;

  localparam int NODE_DEPTH  = 2048;
  localparam int ENTRY_DEPTH = 1024;
  localparam int MAX_MATCHES = 63;

  localparam int NODE_AW  = $clog2(NODE_DEPTH);
  localparam int ENTRY_AW = $clog2(ENTRY_DEPTH);
  localparam int SKIP_W   = 12;
  localparam int REF_W    = 10;
  localparam int CNT_W    = 6;
  localparam int IN_W     = 232;
  localparam int OUT_W    = 16;
  localparam int DOT_W    = 34;

  localparam logic [1:0] KIND_LOAD_NODE  = 2'd0;
  localparam logic [1:0] KIND_LOAD_ENTRY = 2'd1;
  localparam logic [1:0] KIND_NEAREST    = 2'd2;
  localparam logic [1:0] KIND_ALL        = 2'd3;

  localparam logic REG_RADIUS  = 1'b0;
  localparam logic REG_COS_MIN = 1'b1;

  typedef struct packed {
    logic               leaf;
    logic [SKIP_W-1:0]  skip;
    logic [REF_W-1:0]   eref;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } node_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               vol;
  } entry_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } qry_t;

  typedef struct packed {
    logic [63:0]             dsq;
    logic signed [DOT_W-1:0] dot;
  } match_t;

endpackage

### rtl/bvh_nearest_cache_entry_search.sv
// ---------------------------------------------------------------------------
// bvh_nearest_cache_entry_search
// Stackless skip-pointer BVH walk over node and entry RAMs.
// ---------------------------------------------------------------------------
// Loads write straight into the node or entry RAM. A query walks the
// flattened tree one node per cycle through the node RAM read port, while
// the output does not stall; each leaf adds an entry test (entry RAM read
// plus the four-stage distance and dot pipeline). One item is worked at a
// time; the input is ready again as soon as the final result is registered.
module bvh_nearest_cache_entry_search (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // slot, leaf, skip_to, entry_ref, first_x/y/z, second_x/y/z, volume_flag
  input  logic [bnces_pkg::IN_W-1:0] in_tdata,
  // kind
  input  logic [1:0]                in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // found, entry_index, overflow
  output logic [bnces_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [62:0]               cfg_wdata
);
  import bnces_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NODE = 3'd1;
  localparam logic [2:0] ST_E1   = 3'd2;
  localparam logic [2:0] ST_E2   = 3'd3;
  localparam logic [2:0] ST_E3   = 3'd4;
  localparam logic [2:0] ST_E4   = 3'd5;
  localparam logic [2:0] ST_DEC  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [62:0] radius_r;
  logic signed [29:0] cos_r;
  qry_t qry_r, qry_nxt;
  logic qvol_r, qvol_nxt, all_r, all_nxt;
  logic [SKIP_W-1:0] cur_r, cur_nxt, stop_r, stop_nxt;
  logic first_r, first_nxt, have_r, have_nxt, over_r, over_nxt;
  logic [REF_W-1:0] best_r, best_nxt;
  logic [63:0] bestd_r, bestd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  node_t nd, node_w;
  entry_t ent, ent_w;
  match_t mres;
  logic in_acc, out_free, node_we, ent_we, in_box, ok;
  logic [SKIP_W-1:0] root_stop, stop_eff;
  logic [63:0] thr;
  logic [10:0] slot;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign slot      = in_tdata[10:0];

  assign node_w = '{leaf: in_tdata[11], skip: in_tdata[23:12], eref: in_tdata[33:24],
                    min_x: in_tdata[65:34], min_y: in_tdata[97:66],
                    min_z: in_tdata[129:98], max_x: in_tdata[161:130],
                    max_y: in_tdata[193:162], max_z: in_tdata[225:194]};
  assign ent_w  = '{px: in_tdata[65:34], py: in_tdata[97:66], pz: in_tdata[129:98],
                    nx: in_tdata[145:130], ny: in_tdata[177:162],
                    nz: in_tdata[209:194], vol: in_tdata[226]};
  assign node_we = in_acc && (in_tuser == KIND_LOAD_NODE) && (32'(slot) < NODE_DEPTH);
  assign ent_we  = in_acc && (in_tuser == KIND_LOAD_ENTRY) && (32'(slot) < ENTRY_DEPTH);

  bnces_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(slot[NODE_AW-1:0]), .wdata(node_w),
    .raddr(cur_nxt[NODE_AW-1:0]), .rdata(nd)
  );

  bnces_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRY_DEPTH)) u_entry_ram (
    .clk(clk), .we(ent_we), .waddr(slot[ENTRY_AW-1:0]), .wdata(ent_w),
    .raddr(nd.eref[ENTRY_AW-1:0]), .rdata(ent)
  );

  bnces_match u_match (.clk(clk), .qry(qry_r), .ent(ent), .res(mres));

  assign root_stop = (32'(nd.skip) > NODE_DEPTH) ? SKIP_W'(NODE_DEPTH) : nd.skip;
  assign stop_eff  = first_r ? root_stop : stop_r;
  assign in_box = (qry_r.x >= nd.min_x) && (qry_r.x <= nd.max_x) &&
                  (qry_r.y >= nd.min_y) && (qry_r.y <= nd.max_y) &&
                  (qry_r.z >= nd.min_z) && (qry_r.z <= nd.max_z);
  assign thr = all_r ? {1'b0, radius_r} : bestd_r;
  assign ok  = (32'(nd.eref) < ENTRY_DEPTH) && (ent.vol == qvol_r) &&
               (mres.dsq < thr) &&
               (qvol_r || (mres.dot > DOT_W'(cos_r)));

  always_comb begin
    state_nxt     = state_r;
    qry_nxt       = qry_r;
    qvol_nxt      = qvol_r;
    all_nxt       = all_r;
    cur_nxt       = cur_r;
    stop_nxt      = stop_r;
    first_nxt     = first_r;
    have_nxt      = have_r;
    over_nxt      = over_r;
    best_nxt      = best_r;
    bestd_nxt     = bestd_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser[1]) begin
          qry_nxt   = '{x: in_tdata[65:34], y: in_tdata[97:66], z: in_tdata[129:98],
                        nx: in_tdata[145:130], ny: in_tdata[177:162],
                        nz: in_tdata[209:194]};
          qvol_nxt  = in_tdata[226];
          all_nxt   = (in_tuser == KIND_ALL);
          cur_nxt   = '0;
          first_nxt = 1'b1;
          have_nxt  = 1'b0;
          over_nxt  = 1'b0;
          best_nxt  = '0;
          bestd_nxt = {1'b0, radius_r};
          cnt_nxt   = '0;
          state_nxt = ST_NODE;
        end
      end
      ST_NODE: begin
        stop_nxt  = stop_eff;
        first_nxt = 1'b0;
        priority if (cur_r >= stop_eff) begin
          state_nxt = ST_FIN;
        end else if (nd.leaf) begin
          state_nxt = ST_E1;
        end else if (in_box) begin
          cur_nxt = cur_r + 1'b1;
        end else if (nd.skip <= cur_r) begin
          state_nxt = ST_FIN;
        end else begin
          cur_nxt = nd.skip;
        end
      end
      ST_E1: state_nxt = ST_E2;
      ST_E2: state_nxt = ST_E3;
      ST_E3: state_nxt = ST_E4;
      ST_E4: state_nxt = ST_DEC;
      ST_DEC: begin
        if (!all_r) begin
          if (ok) begin
            have_nxt  = 1'b1;
            best_nxt  = nd.eref;
            bestd_nxt = mres.dsq;
          end
          cur_nxt   = cur_r + 1'b1;
          state_nxt = ST_NODE;
        end else if (ok && (32'(cnt_r) < MAX_MATCHES)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b0;
            out_data_nxt  = {4'b0, 1'b0, nd.eref, 1'b1};
            cnt_nxt       = cnt_r + 1'b1;
            cur_nxt       = cur_r + 1'b1;
            state_nxt     = ST_NODE;
          end
        end else begin
          if (ok) begin
            over_nxt = 1'b1;
          end
          cur_nxt   = cur_r + 1'b1;
          state_nxt = ST_NODE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (all_r) begin
            out_data_nxt = {4'b0, over_r, REF_W'(0), 1'b0};
          end else begin
            out_data_nxt = {4'b0, 1'b0, have_r ? best_r : REF_W'(0), have_r};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      radius_r    <= '0;
      cos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_addr == REG_RADIUS)) begin
        radius_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_addr == REG_COS_MIN)) begin
        cos_r <= cfg_wdata[29:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    qry_r      <= qry_nxt;
    qvol_r     <= qvol_nxt;
    all_r      <= all_nxt;
    cur_r      <= cur_nxt;
    stop_r     <= stop_nxt;
    first_r    <= first_nxt;
    have_r     <= have_nxt;
    over_r     <= over_nxt;
    best_r     <= best_nxt;
    bestd_r    <= bestd_nxt;
    cnt_r      <= cnt_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/bnces_ram.sv
// ---------------------------------------------------------------------------
// bnces_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module bnces_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bnces_match.sv
// ---------------------------------------------------------------------------
// bnces_match
// Four-stage distance and normal dot product pipeline for one entry test.
// ---------------------------------------------------------------------------
module bnces_match (
  input  logic              clk,
  input  bnces_pkg::qry_t   qry,
  input  bnces_pkg::entry_t ent,
  output bnces_pkg::match_t res
);
  import bnces_pkg::*;

  logic signed [32:0] dx, dy, dz;
  logic [32:0] ax_r, ay_r, az_r;
  logic [63:0] sqx_r, sqy_r, sqz_r, sqz2_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [64:0] sxy, sall;
  logic [63:0] sxy_r, sall_r;
  logic signed [DOT_W-1:0] dot_r, dot2_r;

  assign dx = 33'(qry.x) - 33'(ent.px);
  assign dy = 33'(qry.y) - 33'(ent.py);
  assign dz = 33'(qry.z) - 33'(ent.pz);

  assign sxy  = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign sall = {1'b0, sxy_r} + {1'b0, sqz2_r};

  always_ff @(posedge clk) begin
    ax_r <= dx[32] ? 33'(-dx) : 33'(dx);
    ay_r <= dy[32] ? 33'(-dy) : 33'(dy);
    az_r <= dz[32] ? 33'(-dz) : 33'(dz);

    sqx_r <= ax_r[32] ? '1 : ax_r[31:0] * ax_r[31:0];
    sqy_r <= ay_r[32] ? '1 : ay_r[31:0] * ay_r[31:0];
    sqz_r <= az_r[32] ? '1 : az_r[31:0] * az_r[31:0];
    px_r  <= qry.nx * ent.nx;
    py_r  <= qry.ny * ent.ny;
    pz_r  <= qry.nz * ent.nz;

    sxy_r  <= sxy[64] ? '1 : sxy[63:0];
    sqz2_r <= sqz_r;
    dot_r  <= DOT_W'(px_r) + DOT_W'(py_r) + DOT_W'(pz_r);

    sall_r <= sall[64] ? '1 : sall[63:0];
    dot2_r <= dot_r;
  end

  assign res.dsq = sall_r;
  assign res.dot = dot2_r;

endmodule

### rtl/bnces_checker.sv
// ---------------------------------------------------------------------------
// bnces_checker
// Port-level checks for the BVH cache entry search, bound to the top level.
// ---------------------------------------------------------------------------
`include "bvh_nearest_cache_entry_search_defines.svh"

module bnces_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [1:0]                   in_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [bnces_pkg::OUT_W-1:0]  out_tdata,
  input logic                         out_tlast
);
  import bnces_pkg::*;

  `BNCES_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BNCES_ASSERT_NEXT(a_query_busy, in_tvalid && in_tready && in_tuser[1], !in_tready)
  `BNCES_ASSERT_NEXT(a_load_free, in_tvalid && in_tready && !in_tuser[1], in_tready)
  `BNCES_ASSERT_SAME(a_mid_found, out_tvalid && !out_tlast, out_tdata[0])
  `BNCES_ASSERT_SAME(a_ovf_last, out_tvalid && out_tdata[11], out_tlast && !out_tdata[0])

endmodule

bind bvh_nearest_cache_entry_search bnces_checker u_bnces_checker (.*);
